FILE: rtl/acc_cpu_pkg.sv
// Package: opcodes, widths and controller types for the accumulator machine.
package acc_cpu_pkg;
  localparam int ADDR_BITS = 16;
  localparam int MEM_DEPTH = 1 << ADDR_BITS;

  typedef enum logic [7:0] {
    OPC_NOP  = 8'h00,
    OPC_LOD  = 8'h02,
    OPC_LODI = 8'h03,
    OPC_ADD  = 8'h04,
    OPC_SUB  = 8'h06,
    OPC_MUL  = 8'h08,
    OPC_DIV  = 8'h0A,
    OPC_MULU = 8'h0C,
    OPC_DIVU = 8'h0E
  } opcode_t;

  // Datapath byte-address source
  typedef enum logic [2:0] {
    AS_WRITE,
    AS_PC0,
    AS_PC1,
    AS_PC2,
    AS_T0,
    AS_T1
  } asel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OPC,
    ST_AHI,
    ST_ALO,
    ST_W1HI,
    ST_W1LO,
    ST_WPTR,
    ST_W2HI,
    ST_W2LO,
    ST_EXEC,
    ST_DIV,
    ST_DONE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic  mem_we;
    logic  mem_re;
    asel_t asel;
    logic  cap_opc;
    logic  cap_hi;
    logic  t_from_word;
    logic  d_from_word;
    logic  exec;
    logic  div_start;
    logic  div_step;
    logic  div_finish;
    logic  commit;
    logic  load_out;
  } ctl_t;

  typedef struct packed {
    logic [7:0] opcode;
    logic       div_last;
  } sts_t;
endpackage

FILE: rtl/acc_cpu_ram.sv
// Generic single-port RAM with registered read.
module acc_cpu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    if (re) rdata <= mem[addr];
  end
endmodule

FILE: rtl/acc_cpu_dp.sv
// Datapath: registers, memory, multiplier and restoring divider.
module acc_cpu_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  acc_cpu_pkg::ctl_t   ctl,
  output acc_cpu_pkg::sts_t   sts,
  input  logic                in_op,
  input  logic [15:0]         in_addr,
  input  logic [7:0]          in_byte,
  output logic [87:0]         res
);
  import acc_cpu_pkg::*;

  logic [15:0] pc_r, acc_r, dreg_r, pc_nxt, acc_nxt, dreg_nxt;
  logic [31:0] steps_r;
  logic [7:0]  opc_r, hi_r;
  logic [15:0] t_r;
  logic        bad_r, dz_r, bad_nxt, dz_nxt;
  logic [15:0] wr_addr_r;
  logic [7:0]  wr_byte_r;
  logic [ADDR_BITS-1:0] ram_addr;
  logic [7:0]  rdata;
  logic [15:0] word;
  logic [15:0] byte_addr;
  // divider
  logic [15:0] dvd_r, dvs_r, rem_r;
  logic [3:0]  cnt_r;
  logic        neg_r;
  logic [16:0] trial;
  logic [15:0] a_abs, d_abs, quo;
  logic [31:0] prod;

  assign word = {hi_r, rdata};

  always_comb begin
    unique case (ctl.asel)
      AS_WRITE: byte_addr = wr_addr_r;
      AS_PC0:   byte_addr = pc_r;
      AS_PC1:   byte_addr = pc_r + 16'd1;
      AS_PC2:   byte_addr = pc_r + 16'd2;
      AS_T0:    byte_addr = t_r;
      AS_T1:    byte_addr = t_r + 16'd1;
      default:  byte_addr = pc_r;
    endcase
  end
  assign ram_addr = byte_addr[ADDR_BITS-1:0];

  acc_cpu_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_ram (
    .clk(clk), .we(ctl.mem_we), .re(ctl.mem_re), .addr(ram_addr),
    .wdata(wr_byte_r), .rdata(rdata)
  );

  assign a_abs = acc_r[15] ? 16'(-acc_r) : acc_r;
  assign d_abs = dreg_r[15] ? 16'(-dreg_r) : dreg_r;
  assign trial = {rem_r, dvd_r[15]} - {1'b0, dvs_r};
  assign prod  = acc_r * dreg_r;
  assign quo   = neg_r ? 16'(-dvd_r) : dvd_r;

  assign sts.opcode   = opc_r;
  assign sts.div_last = (cnt_r == 4'd15);

  always_comb begin
    pc_nxt = pc_r; acc_nxt = acc_r; dreg_nxt = dreg_r;
    bad_nxt = 1'b0; dz_nxt = 1'b0;
    if (ctl.d_from_word) dreg_nxt = word;
    if (ctl.exec) begin
      unique case (opc_r) inside
        OPC_NOP:  pc_nxt = pc_r + 16'd1;
        OPC_LOD, OPC_LODI: pc_nxt = pc_r + 16'd3;
        OPC_ADD:  begin acc_nxt = acc_r + dreg_r; pc_nxt = pc_r + 16'd1; end
        OPC_SUB:  begin acc_nxt = acc_r - dreg_r; pc_nxt = pc_r + 16'd1; end
        OPC_MUL, OPC_MULU: begin acc_nxt = prod[15:0]; pc_nxt = pc_r + 16'd1; end
        OPC_DIV, OPC_DIVU: begin
          pc_nxt = pc_r + 16'd1;
          dz_nxt = (dreg_r == 16'd0);
        end
        default:  bad_nxt = 1'b1;
      endcase
    end
    // divide by zero keeps the accumulator
    if (ctl.div_finish && !dz_r) acc_nxt = quo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0; acc_r <= '0; dreg_r <= '0; steps_r <= '0;
      bad_r <= 1'b0; dz_r <= 1'b0;
    end else begin
      if (ctl.load_out && !in_op) begin
        bad_r <= 1'b0; dz_r <= 1'b0;
      end
      if (ctl.exec) begin
        pc_r <= pc_nxt; acc_r <= acc_nxt;
        bad_r <= bad_nxt; dz_r <= dz_nxt;
        steps_r <= steps_r + 32'd1;
      end
      if (ctl.d_from_word) dreg_r <= dreg_nxt;
      if (ctl.div_finish) acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      wr_addr_r <= in_addr;
      wr_byte_r <= in_byte;
    end
    if (ctl.cap_opc) opc_r <= rdata;
    if (ctl.cap_hi) hi_r <= rdata;
    if (ctl.t_from_word) t_r <= word;
    if (ctl.div_start) begin
      dvd_r <= (opc_r == OPC_DIV) ? a_abs : acc_r;
      dvs_r <= (opc_r == OPC_DIV) ? d_abs : dreg_r;
      neg_r <= (opc_r == OPC_DIV) && (acc_r[15] ^ dreg_r[15]);
      rem_r <= '0;
      cnt_r <= '0;
    end else if (ctl.div_step) begin
      if (!trial[16]) begin
        rem_r <= trial[15:0];
        dvd_r <= {dvd_r[14:0], 1'b1};
      end else begin
        rem_r <= {rem_r[14:0], dvd_r[15]};
        dvd_r <= {dvd_r[14:0], 1'b0};
      end
      cnt_r <= cnt_r + 4'd1;
    end
  end

  assign res = {6'd0, dz_r, bad_r, steps_r, dreg_r, acc_r, pc_r};
endmodule

FILE: rtl/acc_cpu_ctrl.sv
// Controller: sequences fetch, operand reads, divide and handshakes.
module acc_cpu_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic               in_op,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  acc_cpu_pkg::sts_t  sts,
  output acc_cpu_pkg::ctl_t  ctl
);
  import acc_cpu_pkg::*;

  state_t state_r, state_nxt;
  logic   op_r;
  logic   is_div;

  assign is_div = (sts.opcode == OPC_DIV) || (sts.opcode == OPC_DIVU);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) op_r <= in_op;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = in_op ? ST_OPC : ST_EXEC;
      ST_OPC:  state_nxt = ST_AHI;
      ST_AHI:  state_nxt = ST_ALO;
      ST_ALO:  state_nxt = ST_W1HI;
      ST_W1HI: state_nxt = ST_W1LO;
      ST_W1LO: state_nxt = (sts.opcode == OPC_LOD) ? ST_WPTR : ST_EXEC;
      ST_WPTR: state_nxt = ST_W2HI;
      ST_W2HI: state_nxt = ST_W2LO;
      ST_W2LO: state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = (op_r && is_div) ? ST_DIV : ST_OUT;
      ST_DIV:  if (sts.div_last) state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_OUT;
      ST_OUT:  if (out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    ctl.asel = AS_PC0;
    in_tready = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        ctl.load_out = in_tvalid;
        ctl.mem_re = in_tvalid & in_op;
      end
      ST_OPC: begin
        ctl.cap_opc = 1'b1; ctl.mem_re = 1'b1; ctl.asel = AS_PC1;
      end
      ST_AHI: begin
        ctl.cap_hi = 1'b1; ctl.mem_re = 1'b1; ctl.asel = AS_PC2;
      end
      ST_ALO: begin
        ctl.t_from_word = 1'b1;
      end
      ST_W1HI: begin
        ctl.mem_re = 1'b1; ctl.asel = AS_T0;
      end
      ST_W1LO: begin
        ctl.cap_hi = 1'b1; ctl.mem_re = 1'b1; ctl.asel = AS_T1;
      end
      // indirect: pointer word becomes the next address
      ST_WPTR: begin
        ctl.t_from_word = 1'b1;
      end
      ST_W2HI: begin
        ctl.mem_re = 1'b1; ctl.asel = AS_T0;
      end
      ST_W2LO: begin
        ctl.cap_hi = 1'b1; ctl.mem_re = 1'b1; ctl.asel = AS_T1;
      end
      ST_EXEC: begin
        if (op_r) begin
          ctl.exec = 1'b1;
          ctl.div_start = is_div;
          ctl.d_from_word = sts.opcode inside {OPC_LOD, OPC_LODI};
        end else begin
          ctl.mem_we = 1'b1; ctl.asel = AS_WRITE;
        end
      end
      ST_DIV:  ctl.div_step = 1'b1;
      ST_DONE: ctl.div_finish = 1'b1;
      ST_OUT:  out_tvalid = 1'b1;
      default: ctl = '0;
    endcase
  end
endmodule

FILE: rtl/accumulator_cpu_step.sv
// Top level of the accumulator machine: controller plus datapath.
// Order of work: a write item passes to the write state, then to output; other
// items fetch opcode and address, read a word (LOD then a second word, via a
// pointer), execute, and DIV/DIVU run a 16-step restoring divider before output.
// Throughput: one item at a time; the next item is taken the cycle after the
// result is taken. Memory reads go through a single byte port.
// Reset: rst_n synchronous active low clears pc, acc, dreg, step count and
// flags; byte memory is not cleared and holds garbage until written.
module accumulator_cpu_step (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [23:0]  in_tdata,   // [15:0] mem_addr, [23:16] mem_byte
  input  logic         in_tuser,   // op: 0 write byte, 1 execute
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [87:0]  out_tdata   // pc_now, acc_now, dreg_now, steps_done,
                                   // bad_opcode, div_zero, then zero fill
);
  import acc_cpu_pkg::*;

  ctl_t ctl;
  sts_t sts;
  logic in_op_lat;

  // op is sampled by the datapath only while the item is taken
  assign in_op_lat = in_tuser;

  acc_cpu_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_op(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .sts(sts), .ctl(ctl)
  );

  acc_cpu_dp u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
    .in_op(in_op_lat), .in_addr(in_tdata[15:0]), .in_byte(in_tdata[23:16]),
    .res(out_tdata)
  );
endmodule

FILE: rtl/acc_cpu_chk.sv
// Port checker for the accumulator machine, bound to the top level.
module acc_cpu_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [87:0] out_tdata
);
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while result pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[80] && out_tdata[81])) else $error("both flags");

  a_write_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser |-> ##3 (!out_tdata[80] && !out_tdata[81]))
    else $error("write item raised a flag");
endmodule

bind accumulator_cpu_step acc_cpu_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata)
);
